FILE: rtl/stn_pkg.sv
// Shared types and constants for the source text normalizer.
// No dependencies; used by every module of the block.
package stn_pkg;

  // Default width of the comment and blank-run counters
  localparam int COUNT_WIDTH_DEF = 16;

  // Rewind field width and its saturation value
  localparam int REWIND_W = 17;
  localparam logic [REWIND_W-1:0] REWIND_MAX = '1;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DROP_CR  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEL_CMT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NL_SPACE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLLAPSE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRIM     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_MARK = 3'd5;

  // Comment tracker state codes
  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_MLEND = 3'd2;
  localparam logic [2:0] MODE_QUOTE = 3'd3;
  localparam logic [2:0] MODE_LINE  = 3'd4;
  localparam logic [2:0] MODE_ML    = 3'd5;

  // Character codes
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_BLANK  = 8'd32;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_EOF    = 8'd26;

  // Mode bits
  typedef struct packed {
    logic drop_cr;
    logic del_cmt;
    logic nl_space;
    logic collapse;
    logic trim;
    logic end_mark;
  } stn_cfg_t;

  // One result word
  typedef struct packed {
    logic [REWIND_W-1:0] rewind_count;
    logic                byte_valid;
    logic [7:0]          out_byte;
  } stn_result_t;

endpackage

FILE: rtl/stn_step.sv
// Per-byte next-state and result logic of the source text normalizer.
// Depends on stn_pkg; purely combinational, one byte per evaluation.
module stn_step #(
  parameter int COUNT_WIDTH = stn_pkg::COUNT_WIDTH_DEF
) (
  input  stn_pkg::stn_cfg_t    cfg,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_file,
  input  logic                 escape_pending,
  input  logic [2:0]           comment_mode,
  input  logic [COUNT_WIDTH-1:0] comment_bytes,
  input  logic                 skip_blank,
  input  logic [COUNT_WIDTH-1:0] blank_run,
  output logic                 escape_pending_next,
  output logic [2:0]           comment_mode_next,
  output logic [COUNT_WIDTH-1:0] comment_bytes_next,
  output logic                 skip_blank_next,
  output logic [COUNT_WIDTH-1:0] blank_run_next,
  output logic                 res_valid,
  output stn_pkg::stn_result_t res
);
  import stn_pkg::*;

  localparam int SUM_W = (COUNT_WIDTH + 1 > REWIND_W) ? COUNT_WIDTH + 1 : REWIND_W;

  logic [7:0]             c;
  logic [2:0]             mode;
  logic [COUNT_WIDTH-1:0] cb;
  logic                   esc;
  logic                   closed;
  logic                   drop;
  logic                   keep;
  logic [SUM_W-1:0]       rw_sum;
  logic [COUNT_WIDTH-1:0] rw_cmt;
  logic [COUNT_WIDTH-1:0] rw_trim;

  // Walk one byte through CR dropping, comment tracking, line-end conversion, blank collapse and trimming
  always_comb begin
    c       = data_byte;
    mode    = comment_mode;
    cb      = comment_bytes;
    esc     = escape_pending;
    closed  = 1'b0;
    drop    = 1'b0;
    keep    = 1'b0;
    rw_cmt  = '0;
    rw_trim = '0;
    skip_blank_next = skip_blank;
    blank_run_next  = blank_run;

    if (end_of_file) begin
      // End of file clears per-file state
      mode = MODE_PLAIN;
      cb   = '0;
      esc  = 1'b0;
      skip_blank_next = 1'b0;
      blank_run_next  = '0;
      drop = 1'b1;
    end else if (cfg.drop_cr && c == CH_CR) begin
      drop = 1'b1;
    end else begin
      // Comment, quote and escape tracking
      if (cfg.del_cmt) begin
        if (!esc) begin
          if (mode == MODE_START && c != CH_SLASH && c != CH_STAR) begin
            mode = MODE_PLAIN;
            cb   = '0;
          end
          case (c)
            CH_BSLASH: begin
              esc = 1'b1;
            end
            CH_LF: begin
              if (mode == MODE_MLEND) begin
                mode = MODE_ML;
              end else if (mode != MODE_ML) begin
                rw_cmt = cb;
                cb     = '0;
                mode   = MODE_PLAIN;
              end
            end
            CH_SLASH: begin
              if (mode == MODE_PLAIN) begin
                mode = MODE_START;
              end else if (mode == MODE_START) begin
                mode = MODE_LINE;
              end else if (mode == MODE_MLEND) begin
                rw_cmt = cb;
                cb     = '0;
                mode   = MODE_PLAIN;
                closed = 1'b1;
              end
            end
            CH_STAR: begin
              if (mode == MODE_START) begin
                mode = MODE_ML;
              end else if (mode == MODE_ML) begin
                mode = MODE_MLEND;
              end
            end
            CH_QUOTE: begin
              if (mode == MODE_PLAIN) begin
                mode = MODE_QUOTE;
              end else if (mode == MODE_QUOTE) begin
                mode = MODE_PLAIN;
              end
            end
            default: begin
              if (mode == MODE_MLEND) begin
                mode = MODE_ML;
              end
            end
          endcase
        end else if (c != CH_CR) begin
          esc = 1'b0;
        end
        if (!closed && mode != MODE_PLAIN && mode != MODE_QUOTE && cb != '1) begin
          cb = cb + COUNT_WIDTH'(1);
        end
      end

      if (!closed) begin
        // Line ends to spaces
        if (cfg.nl_space && (c inside {CH_LF, CH_CR})) begin
          c = CH_BLANK;
        end
        keep = 1'b1;
        // Collapse blank runs
        if (cfg.collapse) begin
          if (c inside {CH_BLANK, CH_TAB}) begin
            if (skip_blank) begin
              keep = 1'b0;
            end else begin
              c = CH_BLANK;
              skip_blank_next = 1'b1;
            end
          end else begin
            skip_blank_next = 1'b0;
          end
        end
        // Rewind trailing blanks before a line end
        if (keep && cfg.trim) begin
          if (c inside {CH_LF, CH_CR}) begin
            rw_trim = blank_run;
          end
          if (c inside {CH_BLANK, CH_TAB}) begin
            if (blank_run != '1) begin
              blank_run_next = blank_run + COUNT_WIDTH'(1);
            end
          end else begin
            blank_run_next = '0;
          end
        end
      end
    end

    escape_pending_next = esc;
    comment_mode_next   = mode;
    comment_bytes_next  = cb;
  end

  // Form the result word
  always_comb begin
    rw_sum = SUM_W'(rw_cmt) + SUM_W'(rw_trim);
    res.rewind_count = (rw_sum > SUM_W'(REWIND_MAX)) ? REWIND_MAX
                                                     : rw_sum[REWIND_W-1:0];
    if (end_of_file) begin
      res.rewind_count = '0;
      res.byte_valid   = cfg.end_mark;
      res.out_byte     = cfg.end_mark ? CH_EOF : 8'd0;
      res_valid        = cfg.end_mark;
    end else begin
      res.byte_valid = keep;
      res.out_byte   = keep ? c : 8'd0;
      res_valid      = !drop && (keep || rw_sum != '0);
    end
  end

endmodule

FILE: rtl/stn_out_buf.sv
// Two-word output stage (output register plus skid register).
// Depends on stn_pkg for the result word type.
module stn_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  stn_pkg::stn_result_t push_word,
  output logic                 has_room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stn_pkg::stn_result_t out_word
);
  import stn_pkg::*;

  logic        skid_valid;
  stn_result_t skid_word;
  logic        pop;

  assign pop      = out_valid && out_ready;
  assign has_room = !skid_valid;

  // Advance the output register from the skid or the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid <= skid_valid || push;
      if (skid_valid) begin
        out_word <= skid_word;
        if (push) begin
          skid_word <= push_word;
        end else begin
          skid_valid <= 1'b0;
        end
      end else begin
        out_word <= push_word;
      end
    end else if (push) begin
      // Hold the output word, park the new one
      skid_word  <= push_word;
      skid_valid <= 1'b1;
    end
  end

endmodule

FILE: rtl/source_text_normalizer.sv
// Top level of the source text normalizer: mode registers, per-file state
// and output stage. Depends on stn_pkg, stn_step and stn_out_buf.
//
// Takes one word per clock while in_ready is high (a source byte or an
// end-of-file mark) and gives at most one result word per input word. The
// sustained rate is one word per cycle while the output side keeps up: the
// whole per-byte state update (comment tracker, blank collapse,
// trailing-blank count) is combinational and is registered together with
// the result. A two-word output stage lets input continue while a result
// waits; in_ready drops only after the output side has stalled for two
// results. Mode registers must be written while the block is idle.
module source_text_normalizer #(
  parameter int COUNT_WIDTH = stn_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_file,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stn_pkg::REWIND_W-1:0]  rewind_count,
  output logic                          byte_valid,
  output logic [7:0]                    out_byte,
  input  logic                          cfg_write,
  input  logic [stn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                          cfg_data
);
  import stn_pkg::*;

  stn_cfg_t               cfg;
  logic                   escape_pending;
  logic [2:0]             comment_mode;
  logic [COUNT_WIDTH-1:0] comment_bytes;
  logic                   skip_blank;
  logic [COUNT_WIDTH-1:0] blank_run;

  logic                   escape_pending_next;
  logic [2:0]             comment_mode_next;
  logic [COUNT_WIDTH-1:0] comment_bytes_next;
  logic                   skip_blank_next;
  logic [COUNT_WIDTH-1:0] blank_run_next;

  logic                   res_valid;
  stn_result_t            res;
  stn_result_t            out_word;
  logic                   accept;

  assign accept = in_valid && in_ready;

  // Mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DROP_CR:  cfg.drop_cr  <= cfg_data;
        CFG_DEL_CMT:  cfg.del_cmt  <= cfg_data;
        CFG_NL_SPACE: cfg.nl_space <= cfg_data;
        CFG_COLLAPSE: cfg.collapse <= cfg_data;
        CFG_TRIM:     cfg.trim     <= cfg_data;
        CFG_END_MARK: cfg.end_mark <= cfg_data;
        default: ;
      endcase
    end
  end

  stn_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg                 (cfg),
    .data_byte           (data_byte),
    .end_of_file         (end_of_file),
    .escape_pending      (escape_pending),
    .comment_mode        (comment_mode),
    .comment_bytes       (comment_bytes),
    .skip_blank          (skip_blank),
    .blank_run           (blank_run),
    .escape_pending_next (escape_pending_next),
    .comment_mode_next   (comment_mode_next),
    .comment_bytes_next  (comment_bytes_next),
    .skip_blank_next     (skip_blank_next),
    .blank_run_next      (blank_run_next),
    .res_valid           (res_valid),
    .res                 (res)
  );

  // Per-file state, advanced on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      comment_mode   <= MODE_PLAIN;
      comment_bytes  <= '0;
      skip_blank     <= 1'b0;
      blank_run      <= '0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      comment_mode   <= comment_mode_next;
      comment_bytes  <= comment_bytes_next;
      skip_blank     <= skip_blank_next;
      blank_run      <= blank_run_next;
    end
  end

  stn_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_word (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign rewind_count = out_word.rewind_count;
  assign byte_valid   = out_word.byte_valid;
  assign out_byte     = out_word.out_byte;

endmodule

FILE: rtl/stn_checker.sv
// Port-level checks for the source text normalizer, bound to the top level.
// Depends on stn_pkg for field widths.
module stn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [stn_pkg::REWIND_W-1:0]  rewind_count,
  input logic                          byte_valid,
  input logic [7:0]                    out_byte
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rewind_count)
      && $stable(byte_valid) && $stable(out_byte))
    else $error("result word changed while stalled");

  // A word without a byte must carry a rewind
  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> rewind_count != '0)
    else $error("empty result word");

  // A word without a byte carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("nonzero byte in rewind-only word");

  // Input stalls only after the output side has stalled
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

bind source_text_normalizer stn_checker u_stn_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .rewind_count (rewind_count),
  .byte_valid   (byte_valid),
  .out_byte     (out_byte)
);
